/* hw/rtl/tty_line_discipline_macros.svh */
// Assertion helpers for the tty line discipline.
`ifndef TTY_LINE_DISCIPLINE_MACROS_SVH
`define TTY_LINE_DISCIPLINE_MACROS_SVH

// Same-cycle implication.
`define TLD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tty_line_discipline: check failed");

// Next-cycle implication.
`define TLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tty_line_discipline: check failed");

`endif

/* hw/rtl/tld_pkg.sv */
`default_nettype none
package tld_pkg;

    typedef enum logic [1:0] {
        KIND_PUSH    = 2'd0,
        KIND_SERVICE = 2'd1,
        KIND_REQUEST = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  key_byte;
        logic [15:0] count;
        logic [7:0]  tag;
        logic [31:0] base;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic        popped;
        logic        dropped;
        logic [15:0] count;
        logic [7:0]  tag;
        logic [31:0] base;
    } kop_t;

endpackage
`default_nettype wire

/* hw/rtl/tty_line_discipline.sv */
`default_nettype none
// Canonical terminal input path with one pending reader.
// Item channel (item_valid/item_ready): action 0 pushes key_byte into the key
// FIFO, 1 services one buffered byte through the line editor, 2 posts a read
// request (request_count, request_tag, request_base); action 3 does nothing.
// Result channel (result_valid/result_ready): exactly one result per item, in
// order, carrying echo, buffer store, read completion and key-drop flags.
// Throughput: one item per cycle while result_ready is high; the key FIFO
// memory takes one write or one registered read per item, so every action
// takes the same slot; items pass queue, FIFO stage and output register.
// A two-entry command queue sits ahead of the FIFO stage, and the output
// register decouples the receiver. When result_ready is low the output holds,
// the FIFO stage stalls and the queue fills; item_ready drops once the queue
// holds two entries, at most three transfers after the stall begins.
// Reset clears FIFO pointers and fill, the pending request and result_valid;
// FIFO contents are left as they are.
module tty_line_discipline #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  key_byte,
    input  logic [15:0] request_count,
    input  logic [7:0]  request_tag,
    input  logic [31:0] request_base,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        echo_valid,
    output logic [7:0]  echo_char,
    output logic        store_valid,
    output logic [31:0] store_address,
    output logic [7:0]  store_byte,
    output logic        done_valid,
    output logic [7:0]  done_tag,
    output logic [15:0] done_count,
    output logic        key_dropped
);
    import tld_pkg::*;

    logic       q_valid;
    logic       q_pop;
    cmd_t       q_cmd;
    logic       s1_valid;
    kop_t       s1_op;
    logic [7:0] s1_char;
    logic       s1_take;

    tld_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .action        (action),
        .key_byte      (key_byte),
        .request_count (request_count),
        .request_tag   (request_tag),
        .request_base  (request_base),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_cmd         (q_cmd)
    );

    tld_kfifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_kfifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .s1_valid (s1_valid),
        .s1_op    (s1_op),
        .s1_char  (s1_char),
        .s1_take  (s1_take)
    );

    tld_edit u_edit (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_op         (s1_op),
        .s1_char       (s1_char),
        .s1_take       (s1_take),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .echo_valid    (echo_valid),
        .echo_char     (echo_char),
        .store_valid   (store_valid),
        .store_address (store_address),
        .store_byte    (store_byte),
        .done_valid    (done_valid),
        .done_tag      (done_tag),
        .done_count    (done_count),
        .key_dropped   (key_dropped)
    );

endmodule
`default_nettype wire

/* hw/rtl/tld_front.sv */
`default_nettype none
module tld_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  logic [1:0]     action,
    input  logic [7:0]     key_byte,
    input  logic [15:0]    request_count,
    input  logic [7:0]     request_tag,
    input  logic [31:0]    request_base,
    output logic           q_valid,
    input  logic           q_pop,
    output tld_pkg::cmd_t  q_cmd
);
    import tld_pkg::*;

    localparam logic [1:0] ACT_PUSH    = 2'd0;
    localparam logic [1:0] ACT_SERVICE = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    kind_t      kind;
    logic       push;
    logic       pop;

    always_comb
    begin
        case (action)
            ACT_PUSH:    kind = KIND_PUSH;
            ACT_SERVICE: kind = KIND_SERVICE;
            ACT_REQUEST: kind = KIND_REQUEST;
            default:     kind = KIND_NONE;
        endcase
    end

    assign item_ready = (count_reg != 2'd2);
    assign q_valid    = (count_reg != 2'd0);
    assign q_cmd      = entry_reg[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].kind     <= kind;
            entry_reg[wr_ptr_reg].key_byte <= key_byte;
            entry_reg[wr_ptr_reg].count    <= request_count;
            entry_reg[wr_ptr_reg].tag      <= request_tag;
            entry_reg[wr_ptr_reg].base     <= request_base;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/tld_kfifo.sv */
`default_nettype none
module tld_kfifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_pop,
    input  tld_pkg::cmd_t  q_cmd,
    output logic           s1_valid,
    output tld_pkg::kop_t  s1_op,
    output logic [7:0]     s1_char,
    input  logic           s1_take
);
    import tld_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [FW-1:0] FULL = FW'(FIFO_DEPTH);

    logic [7:0]    fifo_store_reg [FIFO_DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          s1_valid_reg, s1_valid_next;
    kop_t          op_reg;
    logic          advance;
    logic          take_cmd;
    logic          is_full;
    logic          do_push;
    logic          do_pop;

    assign advance  = !s1_valid_reg || s1_take;
    assign q_pop    = advance;
    assign take_cmd = advance && q_valid;
    assign is_full  = (fill_reg == FULL);
    assign do_push  = take_cmd && (q_cmd.kind == KIND_PUSH) && !is_full;
    assign do_pop   = take_cmd && (q_cmd.kind == KIND_SERVICE) && (fill_reg != '0);

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        s1_valid_next = advance ? q_valid : s1_valid_reg;
        if (do_push)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (do_pop)
        begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            op_reg.kind    <= q_cmd.kind;
            op_reg.popped  <= do_pop;
            op_reg.dropped <= (q_cmd.kind == KIND_PUSH) && is_full;
            op_reg.count   <= q_cmd.count;
            op_reg.tag     <= q_cmd.tag;
            op_reg.base    <= q_cmd.base;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_store_reg[head_reg] <= q_cmd.key_byte;
        end
        if (do_pop)
        begin
            rdata_reg <= fifo_store_reg[tail_reg];
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_op    = op_reg;
    assign s1_char  = rdata_reg;

endmodule
`default_nettype wire

/* hw/rtl/tld_edit.sv */
`default_nettype none
module tld_edit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s1_valid,
    input  tld_pkg::kop_t  s1_op,
    input  logic [7:0]     s1_char,
    output logic           s1_take,
    output logic           result_valid,
    input  logic           result_ready,
    output logic           echo_valid,
    output logic [7:0]     echo_char,
    output logic           store_valid,
    output logic [31:0]    store_address,
    output logic [7:0]     store_byte,
    output logic           done_valid,
    output logic [7:0]     done_tag,
    output logic [15:0]    done_count,
    output logic           key_dropped
);
    import tld_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;

    logic [15:0] left_reg, left_next;
    logic [15:0] moved_reg, moved_next;
    logic [31:0] base_reg, base_next;
    logic [7:0]  tag_reg, tag_next;
    logic        result_valid_reg, result_valid_next;

    logic        echo_valid_reg, echo_valid_next;
    logic [7:0]  echo_char_reg, echo_char_next;
    logic        store_valid_reg, store_valid_next;
    logic [31:0] store_address_reg, store_address_next;
    logic [7:0]  store_byte_reg, store_byte_next;
    logic        done_valid_reg, done_valid_next;
    logic [7:0]  done_tag_reg, done_tag_next;
    logic [15:0] done_count_reg, done_count_next;
    logic        key_dropped_reg, key_dropped_next;

    logic        out_load;
    logic        printable;

    assign out_load  = s1_valid && (!result_valid_reg || result_ready);
    assign s1_take   = out_load;
    assign printable = s1_char inside {[CH_SPACE:CH_TILDE]};

    always_comb
    begin
        left_next          = left_reg;
        moved_next         = moved_reg;
        base_next          = base_reg;
        tag_next           = tag_reg;
        echo_valid_next    = 1'b0;
        echo_char_next     = 8'd0;
        store_valid_next   = 1'b0;
        store_address_next = 32'd0;
        store_byte_next    = 8'd0;
        done_valid_next    = 1'b0;
        done_tag_next      = 8'd0;
        done_count_next    = 16'd0;
        key_dropped_next   = 1'b0;
        case (s1_op.kind)
            KIND_PUSH:
            begin
                key_dropped_next = s1_op.dropped;
            end
            KIND_SERVICE:
            begin
                if (s1_op.popped && (left_reg != 16'd0))
                begin
                    if (printable)
                    begin
                        echo_valid_next    = 1'b1;
                        store_valid_next   = 1'b1;
                        store_address_next = base_reg + {16'd0, moved_reg};
                        store_byte_next    = s1_char;
                        moved_next         = moved_reg + 16'd1;
                        left_next          = left_reg - 16'd1;
                    end
                    else if ((s1_char == CH_BS) && (moved_reg != 16'd0))
                    begin
                        echo_valid_next = 1'b1;
                        moved_next      = moved_reg - 16'd1;
                        left_next       = left_reg + 16'd1;
                    end
                    if ((s1_char == CH_NL) || (left_next == 16'd0))
                    begin
                        echo_valid_next = 1'b1;
                        done_valid_next = 1'b1;
                        done_tag_next   = tag_reg;
                        done_count_next = moved_next;
                        left_next       = 16'd0;
                    end
                    if (echo_valid_next)
                    begin
                        echo_char_next = s1_char;
                    end
                end
            end
            KIND_REQUEST:
            begin
                left_next  = s1_op.count;
                tag_next   = s1_op.tag;
                base_next  = s1_op.base;
                moved_next = 16'd0;
            end
            default:
            begin
            end
        endcase
        result_valid_next = out_load ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg         <= 16'd0;
            moved_reg        <= 16'd0;
            base_reg         <= 32'd0;
            tag_reg          <= 8'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (out_load)
            begin
                left_reg  <= left_next;
                moved_reg <= moved_next;
                base_reg  <= base_next;
                tag_reg   <= tag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            echo_valid_reg    <= echo_valid_next;
            echo_char_reg     <= echo_char_next;
            store_valid_reg   <= store_valid_next;
            store_address_reg <= store_address_next;
            store_byte_reg    <= store_byte_next;
            done_valid_reg    <= done_valid_next;
            done_tag_reg      <= done_tag_next;
            done_count_reg    <= done_count_next;
            key_dropped_reg   <= key_dropped_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign echo_valid    = echo_valid_reg;
    assign echo_char     = echo_char_reg;
    assign store_valid   = store_valid_reg;
    assign store_address = store_address_reg;
    assign store_byte    = store_byte_reg;
    assign done_valid    = done_valid_reg;
    assign done_tag      = done_tag_reg;
    assign done_count    = done_count_reg;
    assign key_dropped   = key_dropped_reg;

endmodule
`default_nettype wire

/* hw/rtl/tld_checker.sv */
`default_nettype none
`include "tty_line_discipline_macros.svh"
module tld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic        echo_valid,
    input logic [7:0]  echo_char,
    input logic        store_valid,
    input logic [31:0] store_address,
    input logic [7:0]  store_byte,
    input logic        done_valid,
    input logic        key_dropped
);

    `TLD_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(echo_char) && $stable(store_address))
    `TLD_ASSERT_IMPL(a_store_echoed, clk, rst_n, result_valid && store_valid, echo_valid && (echo_char == store_byte))
    `TLD_ASSERT_IMPL(a_done_echoed, clk, rst_n, result_valid && done_valid, echo_valid)
    `TLD_ASSERT_IMPL(a_drop_alone, clk, rst_n, result_valid && key_dropped, !echo_valid && !store_valid && !done_valid)

endmodule

bind tty_line_discipline tld_checker u_tld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .echo_valid    (echo_valid),
    .echo_char     (echo_char),
    .store_valid   (store_valid),
    .store_address (store_address),
    .store_byte    (store_byte),
    .done_valid    (done_valid),
    .key_dropped   (key_dropped)
);
`default_nettype wire
